[sv/nearest_return_steering_assert.svh]
// Assertion macros for the nearest return steering block.
// Expects signals named clock and reset in the scope of each use.
`ifndef NEAREST_RETURN_STEERING_ASSERT_SVH
`define NEAREST_RETURN_STEERING_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define NRS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define NRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/nrs_pkg.sv]
// Shared types and constants for the nearest return steering block.
// No dependencies; imported by the controller, datapath and top level.
package nrs_pkg;

   localparam int RANGE_W     = 16;
   localparam int NEAR_W      = 10;
   localparam int START_W     = 23;
   localparam int STEP_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int DIST_W      = 16;
   localparam int RATE_W      = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int FRAC_SHIFT  = 8;

   localparam logic signed [START_W-1:0] START_ANGLE_RST  = -23'sd3294199;
   localparam logic [STEP_W-1:0]         ANGLE_STEP_RST   = 16'd1661;
   localparam logic [GAIN_W-1:0]         TURN_GAIN_RST    = 16'd1467;
   localparam logic [DIST_W-1:0]         MAX_DISTANCE_RST = 16'd5000;

   localparam logic [FRAC_SHIFT:0]  ROUND_BIAS = 9'd128;
   localparam logic [RATE_W-1:0]    RATE_MAX   = 32'h7FFF_FFFF;
   localparam logic [RATE_W-1:0]    RATE_MIN   = 32'h8000_0000;
   localparam logic [RANGE_W-1:0]   RANGE_NONE = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_ANGLE  = 8'd0,
      CSR_ANGLE_STEP   = 8'd1,
      CSR_TURN_GAIN    = 8'd2,
      CSR_MAX_DISTANCE = 8'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_FETCH,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SLOT_LEFT2,
      SLOT_LEFT1,
      SLOT_RIGHT1,
      SLOT_RIGHT2
   } slot_type;

   typedef struct packed {
      logic     sample_accept;
      logic     fetch_en;
      slot_type fetch_slot;
      logic     load_result;
   } cmd_type;

endpackage

[sv/nrs_ctrl.sv]
// Scan controller: collects samples, sequences the window readout and
// owns the result handshake. Depends on nrs_pkg.
module nrs_ctrl
   import nrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last_sample,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid && req_last_sample) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (slot_ff == 2'd3) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_COLLECT;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      cmd.sample_accept = 1'b0;
      cmd.fetch_en      = 1'b0;
      cmd.fetch_slot    = slot_type'(slot_ff);
      cmd.load_result   = 1'b0;
      slot_in           = 2'd0;
      case (state_ff)
         ST_COLLECT: begin
            req_ready         = 1'b1;
            cmd.sample_accept = req_valid;
         end
         ST_FETCH: begin
            cmd.fetch_en = 1'b1;
            slot_in      = slot_ff + 2'd1;
         end
         ST_DRAIN: begin
            slot_in = 2'd0;
         end
         ST_DONE: begin
            cmd.load_result = out_free;
         end
         default: begin
            slot_in = 2'd0;
         end
      endcase
   end

   // hold the result until taken; a fresh load wins over a take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_result) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         slot_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/nrs_datapath.sv]
// Datapath: scan memory, running minimum, window readout, turn rate
// pipeline, configuration registers and result register. Depends on nrs_pkg.
module nrs_datapath
   import nrs_pkg::*;
#(
   parameter int MAX_BEAMS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [RANGE_W-1:0]       req_range_sample,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output logic [NEAR_W-1:0]        rsp_near_index,
   output logic [RANGE_W-1:0]       rsp_window_left2,
   output logic [RANGE_W-1:0]       rsp_window_left1,
   output logic [RANGE_W-1:0]       rsp_window_center,
   output logic [RANGE_W-1:0]       rsp_window_right1,
   output logic [RANGE_W-1:0]       rsp_window_right2,
   output logic signed [RATE_W-1:0] rsp_turn_rate,
   output logic                     rsp_target_in_reach
);

   localparam int IDX_W   = $clog2(MAX_BEAMS);
   localparam int CNT_W   = $clog2(MAX_BEAMS + 1);
   localparam int PROD1_W = IDX_W + STEP_W;
   localparam int BEAR_W  = ((PROD1_W > START_W) ? PROD1_W : START_W) + 2;
   localparam int PROD2_W = BEAR_W + GAIN_W + 1;
   localparam int RND_W   = PROD2_W + 1;
   localparam int SHR_W   = RND_W - FRAC_SHIFT;

   // configuration registers
   logic signed [START_W-1:0] start_angle_ff;
   logic [STEP_W-1:0]         angle_step_ff;
   logic [GAIN_W-1:0]         turn_gain_ff;
   logic [DIST_W-1:0]         max_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff  <= START_ANGLE_RST;
         angle_step_ff   <= ANGLE_STEP_RST;
         turn_gain_ff    <= TURN_GAIN_RST;
         max_distance_ff <= MAX_DISTANCE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_ANGLE:  start_angle_ff  <= csr_wdata[START_W-1:0];
            CSR_ANGLE_STEP:   angle_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_TURN_GAIN:    turn_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_MAX_DISTANCE: max_distance_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // per-scan tracking
   logic [RANGE_W-1:0] best_range_ff;
   logic [IDX_W-1:0]   best_index_ff;
   logic [CNT_W-1:0]   beam_count_ff;
   logic               store_en;
   logic               take_best;

   assign store_en  = cmd.sample_accept && (beam_count_ff < CNT_W'(MAX_BEAMS));
   assign take_best = (beam_count_ff == '0) || (req_range_sample < best_range_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.load_result) begin
         best_range_ff <= RANGE_NONE;
         best_index_ff <= '0;
         beam_count_ff <= '0;
      end else if (store_en) begin
         if (take_best) begin
            best_range_ff <= req_range_sample;
            best_index_ff <= beam_count_ff[IDX_W-1:0];
         end
         beam_count_ff <= beam_count_ff + CNT_W'(1);
      end
   end

   // neighbour addresses, gated to beams that exist in this scan
   logic [CNT_W:0]     idx_ext;
   logic [CNT_W:0]     cnt_ext;
   logic               slot_ok;
   logic [IDX_W-1:0]   rd_addr;

   assign idx_ext = (CNT_W + 1)'(best_index_ff);
   assign cnt_ext = (CNT_W + 1)'(beam_count_ff);

   always_comb begin
      slot_ok = 1'b0;
      rd_addr = '0;
      case (cmd.fetch_slot)
         SLOT_LEFT2: begin
            slot_ok = idx_ext >= (CNT_W + 1)'(2);
            if (slot_ok) rd_addr = best_index_ff - IDX_W'(2);
         end
         SLOT_LEFT1: begin
            slot_ok = idx_ext >= (CNT_W + 1)'(1);
            if (slot_ok) rd_addr = best_index_ff - IDX_W'(1);
         end
         SLOT_RIGHT1: begin
            slot_ok = (idx_ext + (CNT_W + 1)'(1)) < cnt_ext;
            if (slot_ok) rd_addr = best_index_ff + IDX_W'(1);
         end
         SLOT_RIGHT2: begin
            slot_ok = (idx_ext + (CNT_W + 1)'(2)) < cnt_ext;
            if (slot_ok) rd_addr = best_index_ff + IDX_W'(2);
         end
         default: begin
            slot_ok = 1'b0;
         end
      endcase
   end

   // scan memory: one write port, one registered read port
   logic [RANGE_W-1:0] scan_mem [MAX_BEAMS];
   logic [RANGE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_en) scan_mem[beam_count_ff[IDX_W-1:0]] <= req_range_sample;
      if (cmd.fetch_en) rd_data_ff <= scan_mem[rd_addr];
   end

   logic     cap_en_ff;
   slot_type cap_slot_ff;
   logic     cap_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff <= 1'b0;
      end else begin
         cap_en_ff <= cmd.fetch_en;
      end
   end

   always_ff @(posedge clock) begin
      cap_slot_ff <= cmd.fetch_slot;
      cap_ok_ff   <= slot_ok;
   end

   logic [RANGE_W-1:0] win_l2_ff, win_l1_ff, win_r1_ff, win_r2_ff;

   always_ff @(posedge clock) begin
      if (cap_en_ff) begin
         case (cap_slot_ff)
            SLOT_LEFT2:  win_l2_ff <= cap_ok_ff ? rd_data_ff : '0;
            SLOT_LEFT1:  win_l1_ff <= cap_ok_ff ? rd_data_ff : '0;
            SLOT_RIGHT1: win_r1_ff <= cap_ok_ff ? rd_data_ff : best_range_ff;
            SLOT_RIGHT2: win_r2_ff <= cap_ok_ff ? rd_data_ff : best_range_ff;
            default: ;
         endcase
      end
   end

   // turn rate: index*step, add start, times gain, round and saturate
   logic [PROD1_W-1:0]        prod1_ff;
   logic signed [BEAR_W-1:0]  bearing_ff;
   logic signed [PROD2_W-1:0] prod2_ff;
   logic signed [GAIN_W:0]    gain_s;

   assign gain_s = $signed({1'b0, turn_gain_ff});

   always_ff @(posedge clock) begin
      prod1_ff   <= PROD1_W'(best_index_ff) * PROD1_W'(angle_step_ff);
      bearing_ff <= BEAR_W'(start_angle_ff) + $signed(BEAR_W'(prod1_ff));
      prod2_ff   <= PROD2_W'(bearing_ff) * PROD2_W'(gain_s);
   end

   logic [RND_W-1:0]  rnd_sum;
   logic [SHR_W-1:0]  rnd_q;
   logic              rate_fits;
   logic [RATE_W-1:0] rate_sat;
   logic              reach;

   assign rnd_sum   = RND_W'(prod2_ff) + RND_W'(ROUND_BIAS);
   assign rnd_q     = rnd_sum[RND_W-1:FRAC_SHIFT];
   assign rate_fits = (&rnd_q[SHR_W-1:RATE_W-1]) || !(|rnd_q[SHR_W-1:RATE_W-1]);
   assign rate_sat  = rate_fits ? rnd_q[RATE_W-1:0] :
                      (rnd_q[SHR_W-1] ? RATE_MIN : RATE_MAX);
   assign reach     = (best_range_ff != '0) && (best_range_ff < max_distance_ff);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_near_index      <= NEAR_W'(best_index_ff);
         rsp_window_left2    <= win_l2_ff;
         rsp_window_left1    <= win_l1_ff;
         rsp_window_center   <= best_range_ff;
         rsp_window_right1   <= win_r1_ff;
         rsp_window_right2   <= win_r2_ff;
         rsp_turn_rate       <= reach ? $signed(rate_sat) : '0;
         rsp_target_in_reach <= reach;
      end
   end

endmodule

[sv/nearest_return_steering.sv]
// Nearest return steering: one range sample accepted per cycle while a scan streams in.
// After the last sample, req_ready drops for four neighbour reads through the scan
// memory's one read port, a capture step and the load step, which waits until the
// result side is free; a scan's result is loaded in that load step. Configuration
// writes are never stalled. Synchronous reset clears control and per-scan
// tracking and restores register defaults; the scan memory is not cleared.
`include "nearest_return_steering_assert.svh"
module nearest_return_steering
   import nrs_pkg::*;
#(
   parameter int MAX_BEAMS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [RANGE_W-1:0]       req_range_sample,
   input  logic                     req_last_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [NEAR_W-1:0]        rsp_near_index,
   output logic [RANGE_W-1:0]       rsp_window_left2,
   output logic [RANGE_W-1:0]       rsp_window_left1,
   output logic [RANGE_W-1:0]       rsp_window_center,
   output logic [RANGE_W-1:0]       rsp_window_right1,
   output logic [RANGE_W-1:0]       rsp_window_right2,
   output logic signed [RATE_W-1:0] rsp_turn_rate,
   output logic                     rsp_target_in_reach,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   nrs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd)
   );

   nrs_datapath #(
      .MAX_BEAMS (MAX_BEAMS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_range_sample    (req_range_sample),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_near_index      (rsp_near_index),
      .rsp_window_left2    (rsp_window_left2),
      .rsp_window_left1    (rsp_window_left1),
      .rsp_window_center   (rsp_window_center),
      .rsp_window_right1   (rsp_window_right1),
      .rsp_window_right2   (rsp_window_right2),
      .rsp_turn_rate       (rsp_turn_rate),
      .rsp_target_in_reach (rsp_target_in_reach)
   );

   // a closed scan stops intake until its result is loaded
   `NRS_ASSERT_NEXT(a_scan_end_stall, req_valid && req_ready && req_last_sample, !req_ready, "intake open after scan end")
   `NRS_ASSERT_SAME(a_idle_rate, rsp_valid && !rsp_target_in_reach, rsp_turn_rate == '0, "turn rate issued out of reach")
   `NRS_ASSERT_SAME(a_reach_nonzero, rsp_valid && rsp_target_in_reach, rsp_window_center != '0, "zero range marked in reach")

endmodule

[bench/nearest_return_checker.sv]
// Checker for the nearest return steering block: follows the sample, register and
// result channels, predicts each scan's window and turn rate, and counts mismatches.
// Depends on nrs_pkg for widths, register indexes and reset values.
module nearest_return_checker
   import nrs_pkg::*;
#(
   parameter int MAX_BEAMS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [RANGE_W-1:0]       req_range_sample,
   input  logic                     req_last_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [NEAR_W-1:0]        rsp_near_index,
   input  logic [RANGE_W-1:0]       rsp_window_left2,
   input  logic [RANGE_W-1:0]       rsp_window_left1,
   input  logic [RANGE_W-1:0]       rsp_window_center,
   input  logic [RANGE_W-1:0]       rsp_window_right1,
   input  logic [RANGE_W-1:0]       rsp_window_right2,
   input  logic signed [RATE_W-1:0] rsp_turn_rate,
   input  logic                     rsp_target_in_reach,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       fail_count,
   output int                       pending
);

   typedef struct {
      logic [NEAR_W-1:0]        near_index;
      logic [RANGE_W-1:0]       left2;
      logic [RANGE_W-1:0]       left1;
      logic [RANGE_W-1:0]       center;
      logic [RANGE_W-1:0]       right1;
      logic [RANGE_W-1:0]       right2;
      logic signed [RATE_W-1:0] turn_rate;
      logic                     in_reach;
   } steer_window_type;

   logic signed [START_W-1:0] start_angle;
   logic [STEP_W-1:0]         angle_step;
   logic [GAIN_W-1:0]         turn_gain;
   logic [DIST_W-1:0]         max_distance;

   logic [RANGE_W-1:0] scan_mem [MAX_BEAMS];
   logic [RANGE_W-1:0] nearest;
   int unsigned        nearest_at;
   int unsigned        beams_held;

   steer_window_type expected_windows [$];

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      steer_window_type want;
      longint           bearing;
      longint           scaled;
      if (reset) begin
         start_angle  = START_ANGLE_RST;
         angle_step   = ANGLE_STEP_RST;
         turn_gain    = TURN_GAIN_RST;
         max_distance = MAX_DISTANCE_RST;
         nearest      = RANGE_NONE;
         nearest_at   = 0;
         beams_held   = 0;
         expected_windows.delete();
         fail_count   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_ANGLE:  start_angle  = csr_wdata[START_W-1:0];
               CSR_ANGLE_STEP:   angle_step   = csr_wdata[STEP_W-1:0];
               CSR_TURN_GAIN:    turn_gain    = csr_wdata[GAIN_W-1:0];
               CSR_MAX_DISTANCE: max_distance = csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            // drop samples once the store is full, but still honour the last flag
            if (beams_held < MAX_BEAMS) begin
               scan_mem[beams_held] = req_range_sample;
               if (beams_held == 0 || req_range_sample < nearest) begin
                  nearest    = req_range_sample;
                  nearest_at = beams_held;
               end
               beams_held++;
            end
            if (req_last_sample) begin
               want.near_index = nearest_at[NEAR_W-1:0];
               want.center     = nearest;
               want.left2      = (nearest_at >= 2) ? scan_mem[nearest_at-2] : '0;
               want.left1      = (nearest_at >= 1) ? scan_mem[nearest_at-1] : '0;
               want.right1     = (nearest_at + 1 < beams_held) ? scan_mem[nearest_at+1] : nearest;
               want.right2     = (nearest_at + 2 < beams_held) ? scan_mem[nearest_at+2] : nearest;
               want.in_reach   = (nearest != 0) && (nearest < max_distance);
               want.turn_rate  = '0;
               if (want.in_reach) begin
                  bearing = longint'(start_angle) + longint'(nearest_at) * longint'(angle_step);
                  // round half up, then clamp to the rate width
                  scaled  = (bearing * longint'(turn_gain) + 128) >>> FRAC_SHIFT;
                  if (scaled > 64'sd2147483647)
                     scaled = 64'sd2147483647;
                  else if (scaled < -64'sd2147483648)
                     scaled = -64'sd2147483648;
                  want.turn_rate = scaled[RATE_W-1:0];
               end
               expected_windows.push_back(want);
               nearest    = RANGE_NONE;
               nearest_at = 0;
               beams_held = 0;
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, actual near_index %0d",
                        $time, rsp_near_index);
               fail_count++;
            end else begin
               want = expected_windows.pop_front();
               compare_field("near_index", want.near_index, rsp_near_index);
               compare_field("window_left2", want.left2, rsp_window_left2);
               compare_field("window_left1", want.left1, rsp_window_left1);
               compare_field("window_center", want.center, rsp_window_center);
               compare_field("window_right1", want.right1, rsp_window_right1);
               compare_field("window_right2", want.right2, rsp_window_right2);
               compare_field("turn_rate", longint'(want.turn_rate), longint'(rsp_turn_rate));
               compare_field("target_in_reach", want.in_reach, rsp_target_in_reach);
            end
         end
      end
      pending <= expected_windows.size();
   end

endmodule

[bench/tb_top.sv]
// Top of the nearest return steering bench: clock, reset, scan stimulus and register
// settings, with the block and nearest_return_checker side by side.
// Depends on nrs_pkg, nearest_return_steering and nearest_return_checker.
module tb_top;
   import nrs_pkg::*;

   localparam int BEAM_LIMIT  = 1024;
   localparam int QUIET_LIMIT = 1000;
   localparam int PHASES      = 8;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [RANGE_W-1:0]       req_range_sample = '0;
   logic                     req_last_sample = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [NEAR_W-1:0]        rsp_near_index;
   logic [RANGE_W-1:0]       rsp_window_left2;
   logic [RANGE_W-1:0]       rsp_window_left1;
   logic [RANGE_W-1:0]       rsp_window_center;
   logic [RANGE_W-1:0]       rsp_window_right1;
   logic [RANGE_W-1:0]       rsp_window_right2;
   logic signed [RATE_W-1:0] rsp_turn_rate;
   logic                     rsp_target_in_reach;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int          fail_count;
   int          pending;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b0;
   int unsigned reach_mm = MAX_DISTANCE_RST;

   int unsigned probe_range [21] = '{0, 65535, 65535, 500, 600, 100, 700, 800, 100, 50, 50,
                                     9, 3, 9, 9, 5000, 4999, 5000, 65535, 0, 65535};
   bit          probe_last  [21] = '{1, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1,
                                     0, 0, 0, 1, 0, 1, 1, 0, 0, 1};

   nearest_return_steering #(.MAX_BEAMS(BEAM_LIMIT)) dut (.*);

   nearest_return_checker #(.MAX_BEAMS(BEAM_LIMIT)) steer_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: hold ready low for a drawn number of cycles after each item
   always @(posedge clock) begin : result_sink
      int w;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 39) == 0)
            rx_calm = !rx_calm;
         w = rx_calm ? 0 : $urandom_range(0, 18);
         stall_left <= w;
         rsp_ready  <= (w == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [RANGE_W-1:0] pick_range(input int unsigned reach);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return RANGE_NONE;
         2, 3:    return RANGE_W'($urandom());
         4:       return RANGE_W'($urandom_range(1, 20));
         5:       return RANGE_W'(reach + $urandom_range(0, 2) - 1);
         6:       return RANGE_W'($urandom_range(1, 8000));
         default: return RANGE_W'($urandom_range(100, 400));
      endcase
   endfunction

   task automatic send_item(input logic [RANGE_W-1:0] beam_range, input logic last);
      int gap;
      if ($urandom_range(0, 39) == 0)
         tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_range_sample <= beam_range;
      req_last_sample  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // hold the sender until every expected result is back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin : stimulus
      int          sa;
      int unsigned st;
      int unsigned gn;
      int unsigned md;
      int          phase_items;
      int          len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: begin sa = -3294199; st = 0;     gn = 0;     md = 0;     end
               2: begin sa = 3294199;  st = 65535; gn = 65535; md = 65535; end
               3: begin sa = 0;        st = 1;     gn = 256;   md = 1;     end
               PHASES - 1: begin
                  sa = START_ANGLE_RST;
                  st = ANGLE_STEP_RST;
                  gn = TURN_GAIN_RST;
                  md = MAX_DISTANCE_RST;
               end
               default: begin
                  sa = int'($urandom_range(0, 6588398)) - 3294199;
                  st = $urandom_range(0, 65535);
                  gn = $urandom_range(0, 65535);
                  md = $urandom_range(0, 65535);
               end
            endcase
            // an index past the last register must be ignored
            write_csr(CSR_INDEX_W'($urandom_range(CSR_MAX_DISTANCE + 1, 255)), $urandom());
            write_csr(CSR_START_ANGLE, {9'($urandom()), 23'(sa)});
            write_csr(CSR_ANGLE_STEP, {16'($urandom()), 16'(st)});
            write_csr(CSR_TURN_GAIN, {16'($urandom()), 16'(gn)});
            write_csr(CSR_MAX_DISTANCE, {16'($urandom()), 16'(md)});
            csr_valid <= 1'b0;
            reach_mm = md;
         end

         if (p == 0) begin
            for (int i = 0; i < 21; i++)
               send_item(RANGE_W'(probe_range[i]), probe_last[i]);
         end

         if (p == 2) begin
            // overlong scan: nearest on the final stored beam, then ignored zeros
            for (int i = 0; i < BEAM_LIMIT + 3; i++) begin
               if (i < BEAM_LIMIT - 1)
                  send_item(RANGE_W'($urandom_range(2, 65535)), 1'b0);
               else if (i == BEAM_LIMIT - 1)
                  send_item(RANGE_W'(1), 1'b0);
               else
                  send_item('0, i == BEAM_LIMIT + 2);
            end
         end

         phase_items = 0;
         while (phase_items < 65) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               send_item(pick_range(reach_mm), i == len - 1);
            phase_items += len;
            if ($urandom_range(0, 9) == 0)
               settle();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/nrs_pkg.sv
sv/nrs_ctrl.sv
sv/nrs_datapath.sv
sv/nearest_return_steering.sv
bench/nearest_return_checker.sv
bench/tb_top.sv
